FILE: hdl/uac_pkg.sv
// Shared types and constants for the unique address counter.
`default_nettype none

package uac_pkg;

   localparam int ADDR_W     = 48;
   localparam int STRENGTH_W = 8;
   localparam int STATUS_W   = 2;
   localparam int DISTINCT_W = 6;
   localparam int COUNT_W    = 32;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_KNOWN   = 2'd0,
      STATUS_NEW     = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // Outcome of one lookup, handed from the sequencer to the statistics logic.
   typedef struct packed {
      logic       done;
      status_type status;
   } uac_result_type;

endpackage

`default_nettype wire

FILE: hdl/uac_if.sv
// Valid/ready channel interfaces for advertisement beats and result beats.
`default_nettype none

interface uac_req_if
   import uac_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [ADDR_W-1:0]            device_address;
   logic signed [STRENGTH_W-1:0] signal_strength;

   modport source (output valid, output device_address, output signal_strength,
                   input ready);
   modport sink   (input valid, input device_address, input signal_strength,
                   output ready);
endinterface

interface uac_rsp_if
   import uac_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          address_status;
   logic [DISTINCT_W-1:0]        distinct_count;
   logic                         overflowed;
   logic [COUNT_W-1:0]           advert_total;
   logic [COUNT_W-1:0]           dropped_total;
   logic signed [STRENGTH_W-1:0] latest_strength;

   modport source (output valid, output address_status, output distinct_count,
                   output overflowed, output advert_total, output dropped_total,
                   output latest_strength, input ready);
   modport sink   (input valid, input address_status, input distinct_count,
                   input overflowed, input advert_total, input dropped_total,
                   input latest_strength, output ready);
endinterface

`default_nettype wire

FILE: hdl/uac_table.sv
// Address table memory: one write port, one registered read port.
`default_nettype none

module uac_table
   import uac_pkg::*;
#(
   parameter  int TABLE_DEPTH = 32,
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IW-1:0]     wr_index,
   input  wire logic [ADDR_W-1:0] wr_data,
   input  wire logic [IW-1:0]     rd_index,
   output logic      [ADDR_W-1:0] rd_data
);

   logic [ADDR_W-1:0] mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/uac_ctrl.sv
// Lookup sequencer: walks the table through one compare unit and appends new addresses.
`default_nettype none

module uac_ctrl
   import uac_pkg::*;
#(
   parameter  int TABLE_DEPTH = 32,
   localparam int CW = $clog2(TABLE_DEPTH + 1),
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [ADDR_W-1:0] req_address,
   output logic                   req_ready,
   input  wire logic              out_free,
   output logic [IW-1:0]          rd_index,
   input  wire logic [ADDR_W-1:0] rd_data,
   output logic                   wr_en,
   output logic [IW-1:0]          wr_index,
   output logic [ADDR_W-1:0]      wr_data,
   output uac_result_type         result,
   output logic [CW-1:0]          fill_count
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              pend_ff, pend_in;
   logic              found_ff, found_in;

   logic       accept;
   logic       hit;
   logic       issue_now;
   logic       scan_end;
   logic       room;
   status_type status_c;

   // The shared comparator: checks the entry read on the previous cycle.
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign hit       = pend_ff && (rd_data == addr_ff);
   assign issue_now = (state_ff == ST_SCAN) && (issue_ff != fill_ff);
   assign scan_end  = hit || (!pend_ff && (issue_ff == fill_ff));
   assign room      = fill_ff < CW'(TABLE_DEPTH);

   always_comb begin
      if (found_ff) begin
         status_c = STATUS_KNOWN;
      end else if (room) begin
         status_c = STATUS_NEW;
      end else begin
         status_c = STATUS_DROPPED;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      result.done   = 1'b0;
      result.status = status_c;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            req_ready = 1'b0;
         end
         ST_DECIDE: begin
            result.done = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rd_index   = issue_ff[IW-1:0];
   assign wr_en      = result.done && (status_c == STATUS_NEW);
   assign wr_index   = fill_ff[IW-1:0];
   assign wr_data    = addr_ff;
   assign fill_count = fill_ff;

   always_comb begin
      addr_in  = accept ? req_address : addr_ff;
      issue_in = issue_ff;
      found_in = found_ff;
      fill_in  = fill_ff;
      pend_in  = 1'b0;
      if (accept) begin
         issue_in = '0;
         found_in = 1'b0;
      end else if (state_ff == ST_SCAN) begin
         pend_in = issue_now;
         if (issue_now) begin
            issue_in = issue_ff + 1'b1;
         end
         if (hit) begin
            found_in = 1'b1;
         end
      end
      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(TABLE_DEPTH))
      else $error("fill count exceeds table depth");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (result.done && (result.status == STATUS_NEW)) |=>
         (fill_ff == $past(fill_ff) + 1'b1))
      else $error("new address did not grow the fill count");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (result.done && (result.status == STATUS_DROPPED)) |->
         (fill_ff == CW'(TABLE_DEPTH)))
      else $error("address dropped while table had room");

   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((issue_ff != '0) && (issue_ff <= fill_ff)))
      else $error("compare pending on an entry outside the filled range");

   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DECIDE) |=> $stable(fill_ff))
      else $error("fill count changed outside the decide step");

endmodule

`default_nettype wire

FILE: hdl/unique_address_counter.sv
// Unique address counter top level: sequencer, address table and statistics.
// Flow: an accepted advertisement beat takes the sequencer from idle into a scan that walks the
//   filled table entries, then into a decide step that waits for the output register; a hit ends the walk early.
// One advertisement at a time: a new one is taken only once the last result has left the decide
//   step, and the single table read port that the compare unit uses is walked one entry per cycle.
// Reset: synchronous, active high; clears the fill count, counters and handshake
//   state. Table contents are not cleared: entries at or above the fill count are never compared.
`default_nettype none

module unique_address_counter
   import uac_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   uac_req_if.sink  req_chan,
   uac_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Connections between the sequencer and the table memory.
   logic [IW-1:0]     rd_index;
   logic [ADDR_W-1:0] rd_data;
   logic              wr_en;
   logic [IW-1:0]     wr_index;
   logic [ADDR_W-1:0] wr_data;
   uac_result_type    result;
   logic [CW-1:0]     fill_count;
   logic [CW-1:0]     fill_after;
   logic              out_free;
   logic              req_accept;

   // Running statistics. The advertisement and drop counters wrap at 2^32.
   logic [COUNT_W-1:0] advert_ff, advert_in;
   logic [COUNT_W-1:0] drop_ff, drop_in;

   // Strength of the advertisement being worked on, captured on its beat.
   logic signed [STRENGTH_W-1:0] strength_ff, strength_in;

   // Output register: holds one finished result beat so the sequencer can
   // take the next advertisement while the sink is still stalling.
   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff;
   logic [DISTINCT_W-1:0]        rsp_distinct_ff;
   logic                         rsp_overflow_ff;
   logic [COUNT_W-1:0]           rsp_advert_ff;
   logic [COUNT_W-1:0]           rsp_drop_ff;
   logic signed [STRENGTH_W-1:0] rsp_strength_ff;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;

   uac_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_address (req_chan.device_address),
      .req_ready   (req_chan.ready),
      .out_free    (out_free),
      .rd_index    (rd_index),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_index    (wr_index),
      .wr_data     (wr_data),
      .result      (result),
      .fill_count  (fill_count)
   );

   uac_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_data  (wr_data),
      .rd_index (rd_index),
      .rd_data  (rd_data)
   );

   // The fill count reported is the one after this advertisement is stored.
   assign fill_after = fill_count + CW'(result.status == STATUS_NEW);

   always_comb begin
      advert_in    = advert_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      strength_in  = req_accept ? req_chan.signal_strength : strength_ff;
      if (result.done) begin
         advert_in    = advert_ff + 1'b1;
         rsp_valid_in = 1'b1;
         if (result.status == STATUS_DROPPED) begin
            drop_in = drop_ff + 1'b1;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         advert_ff    <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         advert_ff    <= advert_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: loaded only when a new result beat is formed.
   always_ff @(posedge clock) begin
      strength_ff <= strength_in;
      if (result.done) begin
         rsp_status_ff   <= result.status;
         rsp_distinct_ff <= DISTINCT_W'(fill_after);
         rsp_overflow_ff <= (drop_in != '0);
         rsp_advert_ff   <= advert_in;
         rsp_drop_ff     <= drop_in;
         rsp_strength_ff <= strength_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.address_status  = STATUS_W'(rsp_status_ff);
   assign rsp_chan.distinct_count  = rsp_distinct_ff;
   assign rsp_chan.overflowed      = rsp_overflow_ff;
   assign rsp_chan.advert_total    = rsp_advert_ff;
   assign rsp_chan.dropped_total   = rsp_drop_ff;
   assign rsp_chan.latest_strength = rsp_strength_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the unique address counter: table-driven and random beats.

module tb;
   import uac_pkg::*;

   localparam int TABLE_DEPTH  = 32;
   localparam int RANDOM_BEATS = 1400;

   // One expected result beat, laid out like the result channel payload.
   typedef struct packed {
      status_type                   status;
      logic [DISTINCT_W-1:0]        distinct;
      logic                         overflowed;
      logic [COUNT_W-1:0]           adverts;
      logic [COUNT_W-1:0]           drops;
      logic signed [STRENGTH_W-1:0] strength;
   } lookup_outcome_type;

   // One row of the directed table. Rows with has_outcome set carry a result
   // that is typed in by hand; the others are checked against the predictor.
   typedef struct {
      logic [ADDR_W-1:0]            addr;
      logic signed [STRENGTH_W-1:0] strength;
      bit                           has_outcome;
      lookup_outcome_type           outcome;
   } advert_row_type;

   logic clock = 1'b0;
   logic reset;

   uac_req_if advert_chan ();
   uac_rsp_if result_chan ();

   unique_address_counter #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(advert_chan),
      .rsp_chan(result_chan)
   );

   // Predictor state: its own copy of the address table and the counters.
   logic [ADDR_W-1:0]  stored_addrs [TABLE_DEPTH];
   int                 stored_count = 0;
   logic [COUNT_W-1:0] advert_count = '0;
   logic [COUNT_W-1:0] drop_count   = '0;

   lookup_outcome_type pending_outcomes [$];
   advert_row_type     directed_rows [$];
   int                 mismatch_count = 0;
   int                 result_index   = 0;
   int                 sent_beats     = 0;
   int                 stall_left     = 0;
   int                 cycle_count    = 0;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit on the run. The slowest correct run, with every lookup walking
   // a full table and every beat meeting the longest gap on both sides, stays
   // well under a quarter of this.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // Works out the result of one accepted advertisement and updates the
   // predictor state. A hit anywhere in the filled part of the table leaves the
   // table alone, a miss is appended while there is room, and a miss on a full
   // table only bumps the drop counter.
   function automatic lookup_outcome_type predict_lookup(input logic [ADDR_W-1:0] addr,
                                                         input logic signed [STRENGTH_W-1:0] strength);
      lookup_outcome_type outcome;
      bit                 hit;
      hit = 1'b0;
      advert_count = advert_count + 1'b1;
      for (int i = 0; i < stored_count; i++) begin
         if (stored_addrs[i] == addr) begin
            hit = 1'b1;
         end
      end
      if (hit) begin
         outcome.status = STATUS_KNOWN;
      end else if (stored_count < TABLE_DEPTH) begin
         stored_addrs[stored_count] = addr;
         stored_count++;
         outcome.status = STATUS_NEW;
      end else begin
         drop_count = drop_count + 1'b1;
         outcome.status = STATUS_DROPPED;
      end
      outcome.distinct   = DISTINCT_W'(stored_count);
      outcome.overflowed = (drop_count != '0);
      outcome.adverts    = advert_count;
      outcome.drops      = drop_count;
      outcome.strength   = strength;
      return outcome;
   endfunction

   // Length of one idle stretch: mostly short, now and then long.
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return $urandom_range(1, 2);
      end else if (roll < 92) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   // Adds a directed row. The hand-typed outcome only ever applies before the
   // table fills, so nothing has been dropped yet and the strength is echoed.
   task automatic push_row(input logic [ADDR_W-1:0] addr,
                           input logic signed [STRENGTH_W-1:0] strength,
                           input bit has_outcome, input status_type status,
                           input int distinct, input int adverts);
      advert_row_type row;
      row.addr                = addr;
      row.strength            = strength;
      row.has_outcome         = has_outcome;
      row.outcome.status      = status;
      row.outcome.distinct    = DISTINCT_W'(distinct);
      row.outcome.overflowed  = 1'b0;
      row.outcome.adverts     = COUNT_W'(adverts);
      row.outcome.drops       = '0;
      row.outcome.strength    = strength;
      directed_rows.push_back(row);
   endtask

   // Offers one advertisement beat, holding it until the block takes it. Called
   // and returning at a falling edge. The valid line is only lowered when a gap
   // is wanted, so back-to-back beats never see two assignments in one step.
   task automatic send_advert(input logic [ADDR_W-1:0] addr,
                              input logic signed [STRENGTH_W-1:0] strength,
                              input bit has_outcome, input lookup_outcome_type typed_outcome);
      lookup_outcome_type predicted;
      int                 gap;
      gap = 0;
      // Out of every 200 beats, the first 50 come with no sender gaps at all.
      if ((sent_beats % 200) >= 50 && $urandom_range(0, 99) >= 55) begin
         gap = pick_idle();
      end
      if (gap > 0) begin
         advert_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      advert_chan.valid           <= 1'b1;
      advert_chan.device_address  <= addr;
      advert_chan.signal_strength <= strength;
      do begin
         @(posedge clock);
      end while (!(advert_chan.valid && advert_chan.ready));
      // The predictor always runs so that its state tracks the block, even when
      // the row brings its own expected result.
      predicted = predict_lookup(addr, strength);
      pending_outcomes.push_back(has_outcome ? typed_outcome : predicted);
      sent_beats++;
      @(negedge clock);
   endtask

   // Prints one line for a wrong or unexpected result field and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] result beat %0d: %s is %0d, expected %0d",
               $realtime, result_index, what, got, want);
      mismatch_count++;
   endtask

   // Result side back-pressure, changed at the falling edge. Long quiet spells
   // keep ready high, the rest of the time it drops for random stretches.
   initial begin
      result_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count <= cycle_count + 1;
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_chan.ready <= 1'b0;
         end else if ((cycle_count % 2000) < 500 || $urandom_range(0, 99) < 70) begin
            result_chan.ready <= 1'b1;
         end else begin
            stall_left <= pick_idle() - 1;
            result_chan.ready <= 1'b0;
         end
      end
   end

   // Result checker: every accepted result beat is matched with the oldest
   // outstanding expectation, one field at a time.
   always @(posedge clock) begin
      lookup_outcome_type want;
      if (!reset && result_chan.valid && result_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("[%0t] result beat %0d arrived with nothing outstanding",
                     $realtime, result_index);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (result_chan.address_status !== want.status)
               report_mismatch("address_status", result_chan.address_status, want.status);
            if (result_chan.distinct_count !== want.distinct)
               report_mismatch("distinct_count", result_chan.distinct_count, want.distinct);
            if (result_chan.overflowed !== want.overflowed)
               report_mismatch("overflowed", result_chan.overflowed, want.overflowed);
            if (result_chan.advert_total !== want.adverts)
               report_mismatch("advert_total", result_chan.advert_total, want.adverts);
            if (result_chan.dropped_total !== want.drops)
               report_mismatch("dropped_total", result_chan.dropped_total, want.drops);
            if (result_chan.latest_strength !== want.strength)
               report_mismatch("latest_strength", result_chan.latest_strength, want.strength);
         end
         result_index++;
      end
   end

   // Main sequence: reset, directed table, random beats, drain, verdict.
   initial begin
      lookup_outcome_type no_outcome;
      logic [ADDR_W-1:0]  addr;
      int                 roll;

      no_outcome = '0;
      advert_chan.valid           = 1'b0;
      advert_chan.device_address  = '0;
      advert_chan.signal_strength = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first four rows can be read straight off the behavior after reset:
      // two new addresses at the extremes of the field, then both seen again,
      // with the strength walking through its extremes.
      push_row(48'h0000_0000_0000,    8'sd0, 1'b1, STATUS_NEW,   1, 1);
      push_row(48'hFFFF_FFFF_FFFF, -8'sd128, 1'b1, STATUS_NEW,   2, 2);
      push_row(48'h0000_0000_0000,  8'sd127, 1'b1, STATUS_KNOWN, 2, 3);
      push_row(48'hFFFF_FFFF_FFFF,   -8'sd1, 1'b1, STATUS_KNOWN, 2, 4);
      // New addresses, four of them one bit away from stored ones, must not be taken as hits.
      push_row(48'h0000_0000_0001,    8'sd1, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'hFFFF_FFFF_FFFE,   -8'sd2, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'h8000_0000_0000, -8'sd127, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'h7FFF_FFFF_FFFF,   8'sd64, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'hAAAA_AAAA_AAAA,   8'sd85, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'h5555_5555_5555,  -8'sd86, 1'b0, STATUS_KNOWN, 0, 0);
      // Hits on the newest entry and on two middle entries of the table.
      push_row(48'h5555_5555_5555,  8'sd127, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'h0000_0000_0001, -8'sd128, 1'b0, STATUS_KNOWN, 0, 0);
      push_row(48'h8000_0000_0000,    8'sd0, 1'b0, STATUS_KNOWN, 0, 0);

      foreach (directed_rows[i]) begin
         send_advert(directed_rows[i].addr, directed_rows[i].strength,
                     directed_rows[i].has_outcome, directed_rows[i].outcome);
      end

      // Random part. Fresh addresses fill the table within the first hundred or
      // so beats, after which misses are dropped. Most beats repeat a stored
      // address so that hits land on every table position, and some flip one
      // bit of a stored address to catch a compare that ignores part of it.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         roll = $urandom_range(0, 99);
         if (stored_count == 0 || roll < 30) begin
            addr = {16'($urandom), 32'($urandom)};
         end else if (roll < 85) begin
            addr = stored_addrs[$urandom_range(0, stored_count - 1)];
         end else begin
            addr = stored_addrs[$urandom_range(0, stored_count - 1)]
                   ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
         end
         send_advert(addr, 8'($urandom), 1'b0, no_outcome);
      end
      advert_chan.valid <= 1'b0;

      // Drain, then give the block a full-table lookup time more to show any
      // stray result beat.
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (50) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
